// ----- src/sioc_pkg.sv -----
// shared types, codes and reset tables for the super i/o config port decoder
`default_nettype none

package sioc_pkg;

   // input word
   typedef struct packed {
      logic [2:0] func;
      logic [9:0] io_port;
      logic [7:0] data;
   } req_type;

   // result word
   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] forward_target;
      logic       smi_level;
      logic       parallel_irq_raise;
      logic       serial_fiq_raise;
      logic       serial_fiq_clear;
      logic       unknown_access;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_INTER  = 2'd1,
      MODE_CONFIG = 2'd2
   } mode_type;

   // function codes
   localparam logic [2:0] FUNC_READ       = 3'd0;
   localparam logic [2:0] FUNC_WRITE      = 3'd1;
   localparam logic [2:0] FUNC_SET_INT1   = 3'd2;
   localparam logic [2:0] FUNC_SET_INT2   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR_INT1 = 3'd4;
   localparam logic [2:0] FUNC_CLEAR_INT2 = 3'd5;

   // forward codes
   localparam logic [2:0] FWD_NONE     = 3'd0;
   localparam logic [2:0] FWD_FLOPPY   = 3'd1;
   localparam logic [2:0] FWD_IDE      = 3'd2;
   localparam logic [2:0] FWD_KBD_DATA = 3'd3;
   localparam logic [2:0] FWD_KBD_CMD  = 3'd4;

   // key values
   localparam logic [7:0] UNLOCK_KEY = 8'h55;
   localparam logic [7:0] LOCK_KEY   = 8'haa;

   // ports
   localparam logic [9:0] PORT_CFG_INDEX = 10'h3f0;
   localparam logic [9:0] PORT_CFG_DATA  = 10'h3f1;
   localparam logic [9:0] PORT_GP_INDEX  = 10'h0ea;
   localparam logic [9:0] PORT_GP_DATA   = 10'h0eb;
   localparam logic [9:0] PORT_KBD_DATA  = 10'h060;
   localparam logic [9:0] PORT_KBD_CMD   = 10'h064;
   localparam logic [9:0] PORT_IDE_LO    = 10'h1f0;
   localparam logic [9:0] PORT_IDE_HI    = 10'h1f7;
   localparam logic [9:0] PORT_IDE_ALT   = 10'h3f6;
   localparam logic [9:0] PORT_PRN_LO    = 10'h278;
   localparam logic [9:0] PORT_PRN_HI    = 10'h27f;
   localparam logic [9:0] PORT_PRN_STAT  = 10'h279;
   localparam logic [9:0] PORT_PRN_CTRL  = 10'h27a;
   localparam logic [9:0] PORT_FDC_LO    = 10'h3f0;
   localparam logic [9:0] PORT_FDC_HI    = 10'h3f7;
   localparam logic [9:0] PORT_SER_LO    = 10'h3f8;
   localparam logic [9:0] PORT_SER_HI    = 10'h3ff;
   localparam logic [9:0] PORT_SER_IER   = 10'h3f9;
   localparam logic [9:0] PORT_SER_IIR   = 10'h3fa;
   localparam logic [9:0] PORT_SER_LCR   = 10'h3fb;
   localparam logic [9:0] PORT_SER_SCR   = 10'h3fe;

   localparam logic [7:0] PRN_STATUS_VALUE = 8'h90;
   localparam logic [7:0] PRN_IRQ_MASK     = 8'h10;
   localparam logic [7:0] SER_IIR_VALUE    = 8'h02;
   localparam logic [7:0] SER_IER_TX_MASK  = 8'h02;

   // gp register file
   localparam int         GP_DEPTH        = 16;
   localparam logic [3:0] GP_MASK_INT1    = 4'd12;
   localparam logic [3:0] GP_MASK_INT2    = 4'd13;
   localparam logic [3:0] GP_PEND_INT1    = 4'd14;
   localparam logic [3:0] GP_PEND_INT2    = 4'd15;
   localparam logic [7:0] IDX_GP_MIRROR   = 8'hb4;
   localparam logic [7:0] IDX_GP_MIRROR_B = 8'hb5;
   localparam logic [7:0] IDX_GP_MIRROR_E = 8'hb7;
   localparam logic [1:0] GP_MIRROR_BANK  = 2'b11;

   localparam int SMALL_DEPTH = 16;
   localparam int LARGE_DEPTH = 256;
   localparam int CFG_WIDTH   = 8;

   function automatic logic [7:0] small_cfg_reset(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'h0:    val = 8'h3b;
         4'h1:    val = 8'h9f;
         4'h2:    val = 8'hdc;
         4'h3:    val = 8'h78;
         4'h6:    val = 8'hff;
         4'hd:    val = 8'h65;
         4'he:    val = 8'h02;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] large_cfg_reset(input logic [7:0] idx);
      logic [7:0] val;
      case (idx)
         8'h03:   val = 8'h03;
         8'h20:   val = 8'h40;
         8'h24:   val = 8'h04;
         8'h26:   val = 8'hf0;
         8'h27:   val = 8'h03;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- src/sioc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module sioc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/sioc_cfg_store.sv -----
// large config store: ram plus per-entry valid bits, reset table and write bypass
`default_nettype none

module sioc_cfg_store (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [7:0] wr_addr,
   input  wire logic [7:0] wr_data,
   input  wire logic [7:0] rd_addr,
   output logic      [7:0] rd_data
);

   logic [sioc_pkg::LARGE_DEPTH-1:0] valid_ff;
   logic [sioc_pkg::LARGE_DEPTH-1:0] valid_in;
   logic       vld_ff;
   logic       byp_ff;
   logic [7:0] byp_data_ff;
   logic [7:0] rst_data_ff;
   logic [7:0] ram_data;
   logic       hit;

   sioc_ram #(
      .WIDTH(sioc_pkg::CFG_WIDTH),
      .DEPTH(sioc_pkg::LARGE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // same-cycle write to the address being read returns the new value
   assign hit = wr_en && (wr_addr == rd_addr);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vld_ff   <= valid_ff[rd_addr];
         byp_ff   <= hit;
      end
      byp_data_ff <= wr_data;
      rst_data_ff <= sioc_pkg::large_cfg_reset(rd_addr);
   end

   assign rd_data = byp_ff ? byp_data_ff : (vld_ff ? ram_data : rst_data_ff);

endmodule

`default_nettype wire

// ----- src/superio_config_port_decoder_core.sv -----
// top level: super i/o configuration port decoder
//
// Request channel (req_valid/req_stall/req_payload) carries one bus access or
// interrupt event per word; the response channel (rsp_valid/rsp_stall/
// rsp_payload) returns exactly one word per request, in order.
// A request word is registered on acceptance, then decoded and applied to the
// register state when it advances to the output, and its response word is held in
// an output register; rsp_valid rises when that register is loaded.
// Throughput is one word per cycle while rsp_stall is low; the only loop is the state
// update, and the large config store is a ram read continuously at the next
// selected index so its data is ready when the next word is decoded.
// When rsp_stall is high the response register holds; the input register
// still takes one more word, after which req_stall rises.
// csr_wr_en/csr_wr_data write the chip variant bit; write it only while
// idle. Synchronous reset clears all state to its power-on defaults (valid bits
// on the large store, no clearing pass); both channels are empty after reset.
`default_nettype none

module superio_config_port_decoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sioc_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sioc_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   logic              variant_ff;
   logic              s1_valid_ff, s1_valid_in;
   sioc_pkg::req_type s1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sioc_pkg::rsp_type rsp_ff, rsp_in;
   logic              advance;
   logic              req_accept;

   sioc_pkg::mode_type mode_ff, mode_in;
   logic [7:0] sel_ff, sel_in;
   logic [7:0] small_ff [sioc_pkg::SMALL_DEPTH];
   logic [7:0] small_in [sioc_pkg::SMALL_DEPTH];
   logic [3:0] gp_sel_ff, gp_sel_in;
   logic [7:0] gp_ff [sioc_pkg::GP_DEPTH];
   logic [7:0] gp_in [sioc_pkg::GP_DEPTH];
   logic [7:0] prn_ff, prn_in;
   logic [7:0] lcr_ff, lcr_in;
   logic [7:0] scr_ff, scr_in;

   logic       big_we;
   logic [7:0] big_data;
   logic       wr_go;
   logic       is_ide;
   logic       is_prn;
   logic       is_fdc;
   logic       is_ser;
   logic [7:0] cfg_rd;
   logic [9:0] p;
   logic [7:0] v;

   // input and output handshakes
   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   sioc_cfg_store u_cfg_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (big_we),
      .wr_addr (sel_ff),
      .wr_data (v),
      .rd_addr (sel_in),
      .rd_data (big_data)
   );

   assign p = s1_ff.io_port;
   assign v = s1_ff.data;

   assign is_ide = ((p >= sioc_pkg::PORT_IDE_LO) && (p <= sioc_pkg::PORT_IDE_HI))
                   || (p == sioc_pkg::PORT_IDE_ALT);
   assign is_prn = (p >= sioc_pkg::PORT_PRN_LO) && (p <= sioc_pkg::PORT_PRN_HI);
   assign is_fdc = (p >= sioc_pkg::PORT_FDC_LO) && (p <= sioc_pkg::PORT_FDC_HI);
   assign is_ser = (p >= sioc_pkg::PORT_SER_LO) && (p <= sioc_pkg::PORT_SER_HI);

   // config register read at the selected index
   always_comb begin
      if (variant_ff) begin
         if ((sel_ff >= sioc_pkg::IDX_GP_MIRROR) && (sel_ff <= sioc_pkg::IDX_GP_MIRROR_E)) begin
            cfg_rd = gp_ff[{sioc_pkg::GP_MIRROR_BANK, sel_ff[1:0]}];
         end else begin
            cfg_rd = big_data;
         end
      end else begin
         cfg_rd = small_ff[sel_ff[3:0]];
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      sel_in    = sel_ff;
      small_in  = small_ff;
      gp_sel_in = gp_sel_ff;
      gp_in     = gp_ff;
      prn_in    = prn_ff;
      lcr_in    = lcr_ff;
      scr_in    = scr_ff;
      big_we    = 1'b0;
      wr_go     = 1'b1;
      rsp_in    = '0;
      if (advance) begin
         case (s1_ff.func)
            sioc_pkg::FUNC_READ: begin
               if ((mode_ff == sioc_pkg::MODE_CONFIG) && (p == sioc_pkg::PORT_CFG_DATA)) begin
                  rsp_in.read_data = cfg_rd;
               end else if (variant_ff && (p == sioc_pkg::PORT_KBD_DATA)) begin
                  rsp_in.forward_target = sioc_pkg::FWD_KBD_DATA;
               end else if (variant_ff && (p == sioc_pkg::PORT_KBD_CMD)) begin
                  rsp_in.forward_target = sioc_pkg::FWD_KBD_CMD;
               end else if (variant_ff && (p == sioc_pkg::PORT_GP_INDEX)) begin
                  rsp_in.read_data = {4'h0, gp_sel_ff};
               end else if (variant_ff && (p == sioc_pkg::PORT_GP_DATA)) begin
                  rsp_in.read_data = gp_ff[gp_sel_ff];
               end else if (is_ide) begin
                  if (!variant_ff) begin
                     rsp_in.forward_target = sioc_pkg::FWD_IDE;
                  end
               end else if (is_prn) begin
                  if (p == sioc_pkg::PORT_PRN_STAT) begin
                     rsp_in.read_data = sioc_pkg::PRN_STATUS_VALUE;
                  end else begin
                     rsp_in.unknown_access = 1'b1;
                  end
               end else if (is_fdc) begin
                  rsp_in.forward_target = sioc_pkg::FWD_FLOPPY;
               end else if (is_ser) begin
                  if (p == sioc_pkg::PORT_SER_IIR) begin
                     rsp_in.serial_fiq_clear = 1'b1;
                     rsp_in.read_data        = sioc_pkg::SER_IIR_VALUE;
                  end else if (p == sioc_pkg::PORT_SER_LCR) begin
                     rsp_in.read_data = lcr_ff;
                  end else if (p == sioc_pkg::PORT_SER_SCR) begin
                     rsp_in.read_data = scr_ff;
                  end else begin
                     rsp_in.unknown_access = 1'b1;
                  end
               end else begin
                  rsp_in.unknown_access = 1'b1;
               end
            end
            sioc_pkg::FUNC_WRITE: begin
               // unlock sequence outside config mode
               if (mode_ff != sioc_pkg::MODE_CONFIG) begin
                  if ((p == sioc_pkg::PORT_CFG_INDEX) && (v == sioc_pkg::UNLOCK_KEY)) begin
                     wr_go = 1'b0;
                     if (variant_ff) begin
                        mode_in = sioc_pkg::MODE_CONFIG;
                     end else begin
                        case (mode_ff)
                           sioc_pkg::MODE_NORMAL: mode_in = sioc_pkg::MODE_INTER;
                           sioc_pkg::MODE_INTER:  mode_in = sioc_pkg::MODE_CONFIG;
                           default:               mode_in = mode_ff;
                        endcase
                     end
                  end else begin
                     mode_in = sioc_pkg::MODE_NORMAL;
                  end
               end
               if (wr_go) begin
                  if (mode_ff == sioc_pkg::MODE_CONFIG) begin
                     if (p == sioc_pkg::PORT_CFG_INDEX) begin
                        if (v == sioc_pkg::LOCK_KEY) begin
                           mode_in = sioc_pkg::MODE_NORMAL;
                        end else begin
                           sel_in = variant_ff ? v : {4'h0, v[3:0]};
                        end
                     end else if (variant_ff) begin
                        if (sel_ff == sioc_pkg::IDX_GP_MIRROR) begin
                           gp_in[sioc_pkg::GP_MASK_INT1] = v;
                        end else if (sel_ff == sioc_pkg::IDX_GP_MIRROR_B) begin
                           gp_in[sioc_pkg::GP_MASK_INT2] = v;
                        end else begin
                           big_we = 1'b1;
                        end
                     end else begin
                        small_in[sel_ff[3:0]] = v;
                     end
                  end else if (variant_ff && (p == sioc_pkg::PORT_KBD_DATA)) begin
                     rsp_in.forward_target = sioc_pkg::FWD_KBD_DATA;
                  end else if (variant_ff && (p == sioc_pkg::PORT_KBD_CMD)) begin
                     rsp_in.forward_target = sioc_pkg::FWD_KBD_CMD;
                  end else if (variant_ff && (p == sioc_pkg::PORT_GP_INDEX)) begin
                     gp_sel_in = v[3:0];
                  end else if (variant_ff && (p == sioc_pkg::PORT_GP_DATA)) begin
                     gp_in[gp_sel_ff] = v;
                  end else if (is_ide) begin
                     if (!variant_ff) begin
                        rsp_in.forward_target = sioc_pkg::FWD_IDE;
                     end
                  end else if (is_prn) begin
                     if (p == sioc_pkg::PORT_PRN_CTRL) begin
                        // irq enable, or strobe bit falling
                        if (((v & sioc_pkg::PRN_IRQ_MASK) != 8'h00)
                            || ((prn_ff[0] != v[0]) && !v[0])) begin
                           rsp_in.parallel_irq_raise = 1'b1;
                        end
                        prn_in = v;
                     end else begin
                        rsp_in.unknown_access = 1'b1;
                     end
                  end else if (is_fdc) begin
                     rsp_in.forward_target = sioc_pkg::FWD_FLOPPY;
                  end else if (is_ser) begin
                     if ((p == sioc_pkg::PORT_SER_IER)
                         && ((v & sioc_pkg::SER_IER_TX_MASK) != 8'h00)) begin
                        rsp_in.serial_fiq_raise = 1'b1;
                     end else if (p == sioc_pkg::PORT_SER_LCR) begin
                        lcr_in = v;
                     end else if (p == sioc_pkg::PORT_SER_SCR) begin
                        scr_in = v;
                     end else begin
                        rsp_in.unknown_access = 1'b1;
                     end
                  end else begin
                     rsp_in.unknown_access = 1'b1;
                  end
               end
            end
            sioc_pkg::FUNC_SET_INT1: begin
               gp_in[sioc_pkg::GP_PEND_INT1] = gp_ff[sioc_pkg::GP_PEND_INT1] | v;
            end
            sioc_pkg::FUNC_SET_INT2: begin
               gp_in[sioc_pkg::GP_PEND_INT2] = gp_ff[sioc_pkg::GP_PEND_INT2] | v;
            end
            sioc_pkg::FUNC_CLEAR_INT1: begin
               gp_in[sioc_pkg::GP_PEND_INT1] = gp_ff[sioc_pkg::GP_PEND_INT1] & ~v;
            end
            sioc_pkg::FUNC_CLEAR_INT2: begin
               gp_in[sioc_pkg::GP_PEND_INT2] = gp_ff[sioc_pkg::GP_PEND_INT2] & ~v;
            end
            default: begin
            end
         endcase
      end
      rsp_in.smi_level = |((gp_in[sioc_pkg::GP_PEND_INT1] & gp_in[sioc_pkg::GP_MASK_INT1])
                         | (gp_in[sioc_pkg::GP_PEND_INT2] & gp_in[sioc_pkg::GP_MASK_INT2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= sioc_pkg::MODE_NORMAL;
         sel_ff       <= '0;
         gp_sel_ff    <= '0;
         prn_ff       <= '0;
         lcr_ff       <= '0;
         scr_ff       <= '0;
         for (int i = 0; i < sioc_pkg::SMALL_DEPTH; i++) begin
            small_ff[i] <= sioc_pkg::small_cfg_reset(4'(i));
         end
         for (int i = 0; i < sioc_pkg::GP_DEPTH; i++) begin
            gp_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            variant_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         sel_ff       <= sel_in;
         gp_sel_ff    <= gp_sel_in;
         prn_ff       <= prn_in;
         lcr_ff       <= lcr_in;
         scr_ff       <= scr_in;
         small_ff     <= small_in;
         gp_ff        <= gp_in;
      end
      if (req_accept) begin
         s1_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- dv/superio_config_port_decoder_checker.sv -----
// checker for the super i/o config port decoder: own decode model and in-order compare

module superio_config_port_decoder_checker
   import sioc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int unsigned n_pending,
   output int unsigned n_errors,
   output int unsigned n_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] SMALL_DEFAULTS [16] = '{
      8'h3b, 8'h9f, 8'hdc, 8'h78, 8'h00, 8'h00, 8'hff, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65, 8'h02, 8'h00
   };

   // decoder state as the testbench sees it
   logic       variant;
   mode_type   cfg_mode;
   logic [7:0] cfg_index;
   logic [7:0] small_cfg [16];
   logic [7:0] large_cfg [256];
   logic [3:0] gp_sel;
   logic [7:0] gp_regs [16];
   logic [7:0] prn_ctrl;
   logic [7:0] line_ctrl;
   logic [7:0] scratch;

   rsp_type     rsp_due_q [$];
   int unsigned errors  = 0;
   int unsigned checked = 0;

   // applies one word to the state and returns the response it must produce
   function automatic rsp_type decode_word(input req_type w);
      rsp_type    r;
      logic [9:0] p;
      logic [7:0] v;
      logic       ide;
      logic       done;
      r    = '0;
      p    = w.io_port;
      v    = w.data;
      ide  = (p >= PORT_IDE_LO && p <= PORT_IDE_HI) || p == PORT_IDE_ALT;
      done = 1'b0;
      if (w.func == FUNC_WRITE) begin
         if (cfg_mode != MODE_CONFIG) begin
            if (p == PORT_CFG_INDEX && v == UNLOCK_KEY) begin
               done = 1'b1;
               if (variant) cfg_mode = MODE_CONFIG;
               else if (cfg_mode == MODE_NORMAL) cfg_mode = MODE_INTER;
               else if (cfg_mode == MODE_INTER) cfg_mode = MODE_CONFIG;
            end else begin
               cfg_mode = MODE_NORMAL;
            end
         end else begin
            done = 1'b1;
            if (p == PORT_CFG_INDEX) begin
               if (v == LOCK_KEY) cfg_mode = MODE_NORMAL;
               else cfg_index = variant ? v : {4'h0, v[3:0]};
            end else if (variant && cfg_index == IDX_GP_MIRROR) begin
               gp_regs[GP_MASK_INT1] = v;
            end else if (variant && cfg_index == IDX_GP_MIRROR_B) begin
               gp_regs[GP_MASK_INT2] = v;
            end else if (variant) begin
               large_cfg[cfg_index] = v;
            end else begin
               small_cfg[cfg_index[3:0]] = v;
            end
         end
         if (!done) begin
            if (variant && p == PORT_KBD_DATA) r.forward_target = FWD_KBD_DATA;
            else if (variant && p == PORT_KBD_CMD) r.forward_target = FWD_KBD_CMD;
            else if (variant && p == PORT_GP_INDEX) gp_sel = v[3:0];
            else if (variant && p == PORT_GP_DATA) gp_regs[gp_sel] = v;
            else if (ide) begin
               if (!variant) r.forward_target = FWD_IDE;
            end else if (p >= PORT_PRN_LO && p <= PORT_PRN_HI) begin
               if (p == PORT_PRN_CTRL) begin
                  // irq on the enable bit or on a falling strobe
                  if ((v & PRN_IRQ_MASK) != 0 || ((prn_ctrl[0] ^ v[0]) && !v[0]))
                     r.parallel_irq_raise = 1'b1;
                  prn_ctrl = v;
               end else begin
                  r.unknown_access = 1'b1;
               end
            end else if (p >= PORT_FDC_LO && p <= PORT_FDC_HI) begin
               r.forward_target = FWD_FLOPPY;
            end else if (p >= PORT_SER_LO && p <= PORT_SER_HI) begin
               if (p == PORT_SER_IER && (v & SER_IER_TX_MASK) != 0) r.serial_fiq_raise = 1'b1;
               else if (p == PORT_SER_LCR) line_ctrl = v;
               else if (p == PORT_SER_SCR) scratch = v;
               else r.unknown_access = 1'b1;
            end else begin
               r.unknown_access = 1'b1;
            end
         end
      end else if (w.func == FUNC_READ) begin
         if (cfg_mode == MODE_CONFIG && p == PORT_CFG_DATA) begin
            if (!variant) r.read_data = small_cfg[cfg_index[3:0]];
            else if (cfg_index >= IDX_GP_MIRROR && cfg_index <= IDX_GP_MIRROR_E)
               r.read_data = gp_regs[GP_MASK_INT1 + 4'(cfg_index - IDX_GP_MIRROR)];
            else r.read_data = large_cfg[cfg_index];
         end else if (variant && p == PORT_KBD_DATA) begin
            r.forward_target = FWD_KBD_DATA;
         end else if (variant && p == PORT_KBD_CMD) begin
            r.forward_target = FWD_KBD_CMD;
         end else if (variant && p == PORT_GP_INDEX) begin
            r.read_data = {4'h0, gp_sel};
         end else if (variant && p == PORT_GP_DATA) begin
            r.read_data = gp_regs[gp_sel];
         end else if (ide) begin
            if (!variant) r.forward_target = FWD_IDE;
         end else if (p >= PORT_PRN_LO && p <= PORT_PRN_HI) begin
            if (p == PORT_PRN_STAT) r.read_data = PRN_STATUS_VALUE;
            else r.unknown_access = 1'b1;
         end else if (p >= PORT_FDC_LO && p <= PORT_FDC_HI) begin
            r.forward_target = FWD_FLOPPY;
         end else if (p >= PORT_SER_LO && p <= PORT_SER_HI) begin
            if (p == PORT_SER_IIR) begin
               r.serial_fiq_clear = 1'b1;
               r.read_data        = SER_IIR_VALUE;
            end else if (p == PORT_SER_LCR) begin
               r.read_data = line_ctrl;
            end else if (p == PORT_SER_SCR) begin
               r.read_data = scratch;
            end else begin
               r.unknown_access = 1'b1;
            end
         end else begin
            r.unknown_access = 1'b1;
         end
      end else begin
         case (w.func)
            FUNC_SET_INT1:   gp_regs[GP_PEND_INT1] = gp_regs[GP_PEND_INT1] | v;
            FUNC_SET_INT2:   gp_regs[GP_PEND_INT2] = gp_regs[GP_PEND_INT2] | v;
            FUNC_CLEAR_INT1: gp_regs[GP_PEND_INT1] = gp_regs[GP_PEND_INT1] & ~v;
            FUNC_CLEAR_INT2: gp_regs[GP_PEND_INT2] = gp_regs[GP_PEND_INT2] & ~v;
            default: ;
         endcase
      end
      r.smi_level = |((gp_regs[GP_PEND_INT1] & gp_regs[GP_MASK_INT1]) |
                      (gp_regs[GP_PEND_INT2] & gp_regs[GP_MASK_INT2]));
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    bad;
      if (reset) begin
         variant   = 1'b0;
         cfg_mode  = MODE_NORMAL;
         cfg_index = '0;
         gp_sel    = '0;
         prn_ctrl  = '0;
         line_ctrl = '0;
         scratch   = '0;
         for (int i = 0; i < 16; i++) begin
            small_cfg[i] = SMALL_DEFAULTS[i];
            gp_regs[i]   = '0;
         end
         for (int i = 0; i < 256; i++) large_cfg[i] = '0;
         large_cfg[8'h03] = 8'h03;
         large_cfg[8'h20] = 8'h40;
         large_cfg[8'h24] = 8'h04;
         large_cfg[8'h26] = 8'hf0;
         large_cfg[8'h27] = 8'h03;
         rsp_due_q.delete();
      end else begin
         if (csr_wr_en) variant = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (rsp_due_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response word: data %02h fwd %0d", got.read_data,
                           got.forward_target);
            end else begin
               want = rsp_due_q.pop_front();
               checked++;
               bad = (got.read_data          !== want.read_data)          ||
                     (got.forward_target     !== want.forward_target)     ||
                     (got.smi_level          !== want.smi_level)          ||
                     (got.parallel_irq_raise !== want.parallel_irq_raise) ||
                     (got.serial_fiq_raise   !== want.serial_fiq_raise)   ||
                     (got.serial_fiq_clear   !== want.serial_fiq_clear)   ||
                     (got.unknown_access     !== want.unknown_access);
               if (bad) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch on response %0d: want data %02h fwd %0d smi %b",
                              checked, want.read_data, want.forward_target, want.smi_level);
                     $display("   prn %b fiq %b/%b unk %b; got data %02h fwd %0d smi %b",
                              want.parallel_irq_raise, want.serial_fiq_raise,
                              want.serial_fiq_clear, want.unknown_access,
                              got.read_data, got.forward_target, got.smi_level);
                     $display("   got prn %b fiq %b/%b unk %b", got.parallel_irq_raise,
                              got.serial_fiq_raise, got.serial_fiq_clear,
                              got.unknown_access);
                  end
               end
            end
         end
         if (req_valid && !req_stall) rsp_due_q.push_back(decode_word(req_payload));
      end
      n_pending <= rsp_due_q.size();
      n_errors  <= errors;
      n_checked <= checked;
   end

endmodule

// ----- dv/tb_superio_config_port_decoder_core.sv -----
// testbench top for the super i/o config port decoder: stimulus, stalls and verdict

module tb_superio_config_port_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;
   import sioc_pkg::*;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int         QUIET_LIMIT = 2000;
   localparam int         SEG_WORDS   = 85;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   int unsigned n_pending;
   int unsigned n_errors;
   int unsigned n_checked;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic cur_variant   = 1'b0;
   int   n_words       = 0;
   int   n_reads       = 0;
   int   n_writes      = 0;
   int   n_events      = 0;
   int   n_other       = 0;
   int   n_switches    = 0;
   int   quiet_cycles  = 0;

   superio_config_port_decoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   superio_config_port_decoder_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .n_pending   (n_pending),
      .n_errors    (n_errors),
      .n_checked   (n_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words sent", quiet_cycles,
                  n_words);
         $display("[superio_config_port_decoder_core] ERROR");
         $finish;
      end
   end

   // present one word, possibly after a random gap, and hold it until taken
   task automatic send_word(input logic [2:0] fn, input logic [9:0] port,
                            input logic [7:0] val);
      req_type w;
      w.func    = fn;
      w.io_port = port;
      w.data    = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_words++;
      if (fn == FUNC_READ) n_reads++;
      else if (fn == FUNC_WRITE) n_writes++;
      else if (fn >= FUNC_SET_INT1 && fn <= FUNC_CLEAR_INT2) n_events++;
      else n_other++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (n_pending != 0) @(posedge clock);
   endtask

   task automatic set_variant(input logic v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_variant = v;
      n_switches++;
   endtask

   task automatic unlock();
      repeat (cur_variant ? 1 : 2) send_word(FUNC_WRITE, PORT_CFG_INDEX, UNLOCK_KEY);
   endtask

   task automatic random_burst();
      int         n;
      logic [7:0] idx;
      logic [9:0] port;
      case ($urandom_range(9))
         0, 1, 2: begin
            // config session: unlock, index/data traffic, usually a lock
            unlock();
            n = $urandom_range(6, 1);
            repeat (n) begin
               case ($urandom_range(2))
                  0: begin
                     if (cur_variant && $urandom_range(1))
                        idx = IDX_GP_MIRROR + 8'($urandom_range(3));
                     else
                        idx = 8'($urandom);
                     send_word(FUNC_WRITE, PORT_CFG_INDEX, idx);
                  end
                  1: begin
                     port = $urandom_range(1) ? PORT_CFG_DATA : 10'($urandom);
                     if (port == PORT_CFG_INDEX) port = PORT_CFG_DATA;
                     send_word(FUNC_WRITE, port, 8'($urandom));
                  end
                  default: send_word(FUNC_READ, PORT_CFG_DATA, 8'($urandom));
               endcase
            end
            if ($urandom_range(5) != 0) send_word(FUNC_WRITE, PORT_CFG_INDEX, LOCK_KEY);
         end
         3: begin
            idx = $urandom_range(1) ? 8'($urandom_range(15, 12)) : 8'($urandom);
            send_word(FUNC_WRITE, PORT_GP_INDEX, idx);
            send_word($urandom_range(1) ? FUNC_WRITE : FUNC_READ, PORT_GP_DATA, 8'($urandom));
            send_word(FUNC_READ, PORT_GP_INDEX, 8'($urandom));
         end
         4: begin
            n = $urandom_range(3, 1);
            repeat (n)
               send_word(3'($urandom_range(FUNC_CLEAR_INT2, FUNC_SET_INT1)), 10'($urandom),
                         8'($urandom));
         end
         5: begin
            port = $urandom_range(1) ? PORT_PRN_LO + 10'($urandom_range(7))
                                     : PORT_SER_LO + 10'($urandom_range(7));
            send_word($urandom_range(1) ? FUNC_WRITE : FUNC_READ, port, 8'($urandom));
         end
         6: begin
            case ($urandom_range(3))
               0:       port = PORT_FDC_LO + 10'($urandom_range(7));
               1:       port = PORT_IDE_LO + 10'($urandom_range(7));
               2:       port = PORT_KBD_DATA;
               default: port = PORT_KBD_CMD;
            endcase
            send_word($urandom_range(1) ? FUNC_WRITE : FUNC_READ, port, 8'($urandom));
         end
         7, 8: send_word(3'($urandom_range(7)), 10'($urandom), 8'($urandom));
         default: begin
            // one unlock key, then something else (a broken unlock in the first variant)
            send_word(FUNC_WRITE, PORT_CFG_INDEX, UNLOCK_KEY);
            port = $urandom_range(1) ? PORT_CFG_INDEX + 10'($urandom_range(1))
                                     : 10'($urandom);
            send_word($urandom_range(1) ? FUNC_WRITE : FUNC_READ, port, 8'($urandom));
         end
      endcase
   endtask

   initial begin
      int goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, first variant
      send_word(FUNC_READ, 10'h000, 8'h00);
      send_word(FUNC_WRITE, 10'h3ff, 8'hff);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, UNLOCK_KEY);
      send_word(FUNC_READ, PORT_CFG_DATA, 8'h00);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, UNLOCK_KEY);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, 8'hfd);
      send_word(FUNC_READ, PORT_CFG_DATA, 8'h00);
      send_word(FUNC_WRITE, 10'h000, 8'h5a);
      send_word(FUNC_READ, PORT_CFG_DATA, 8'h00);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, LOCK_KEY);
      send_word(FUNC_WRITE, PORT_IDE_ALT, 8'h00);
      send_word(FUNC_WRITE, PORT_PRN_CTRL, PRN_IRQ_MASK | 8'h01);
      send_word(FUNC_WRITE, PORT_PRN_CTRL, 8'h00);
      send_word(FUNC_READ, PORT_PRN_STAT, 8'h00);
      send_word(FUNC_WRITE, PORT_SER_IER, SER_IER_TX_MASK);
      send_word(FUNC_WRITE, PORT_SER_IER, ~SER_IER_TX_MASK);
      send_word(FUNC_READ, PORT_SER_IIR, 8'h00);
      send_word(FUNC_SET_INT1, 10'h000, 8'hff);
      send_word(FUNC_UNUSED, 10'h3ff, 8'hff);

      // directed, second variant
      set_variant(1'b1);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, UNLOCK_KEY);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, IDX_GP_MIRROR);
      send_word(FUNC_WRITE, PORT_SER_HI, 8'h01);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, IDX_GP_MIRROR_E);
      send_word(FUNC_READ, PORT_CFG_DATA, 8'h00);
      send_word(FUNC_WRITE, PORT_CFG_INDEX, LOCK_KEY);
      send_word(FUNC_CLEAR_INT1, 10'h000, 8'hff);
      send_word(FUNC_WRITE, PORT_GP_INDEX, 8'hff);
      send_word(FUNC_READ, PORT_GP_DATA, 8'h00);
      send_word(FUNC_READ, PORT_KBD_DATA, 8'h00);
      send_word(FUNC_WRITE, PORT_KBD_CMD, 8'h00);
      send_word(FUNC_READ, PORT_IDE_HI, 8'h00);

      // random: three stall patterns, both variants in each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            set_variant(1'(seg ^ phase));
            goal = n_words + SEG_WORDS;
            while (n_words < goal) random_burst();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      $display("run covered %0d words (%0d reads, %0d writes, %0d interrupt events, %0d unused)",
               n_words, n_reads, n_writes, n_events, n_other);
      $display("%0d responses checked across %0d chip variant switches and three stall mixes",
               n_checked, n_switches);
      if (n_errors == 0 && n_pending == 0) begin
         $display("[superio_config_port_decoder_core] OK");
      end else begin
         $display("[superio_config_port_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
